// ===== src/iirdf_pkg.sv =====
// Shared types and register codes for the second-order direct form 1 IIR filter.
package iirdf_pkg;

	// Widths of the fixed-point quantities
	localparam int unsigned SampleW  = 16;  // input and output samples
	localparam int unsigned FwdW     = 5;   // integer feed-forward weights
	localparam int unsigned FbW      = 21;  // Q5.16 feedback weights
	localparam int unsigned GainW    = 32;  // Q0.32 reciprocal gain
	localparam int unsigned XW       = 32;  // scaled input, Q16.16
	localparam int unsigned YW       = 40;  // output history, Q24.16
	localparam int unsigned FracW    = 16;  // fraction bits of X and Y
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 32;

	// Configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_FWD_OLDEST = 3'd0,
		REG_FWD_MIDDLE = 3'd1,
		REG_FWD_NEWEST = 3'd2,
		REG_FB_OLDEST  = 3'd3,
		REG_FB_RECENT  = 3'd4,
		REG_INV_GAIN   = 3'd5
	} reg_idx_t;

	// Coefficient set as held by the register file (raw bits; signed weights, unsigned gain)
	typedef struct packed {
		logic [FwdW-1:0]  fwd_coef_oldest;
		logic [FwdW-1:0]  fwd_coef_middle;
		logic [FwdW-1:0]  fwd_coef_newest;
		logic [FbW-1:0]   fb_coef_oldest;
		logic [FbW-1:0]   fb_coef_recent;
		logic [GainW-1:0] inv_gain;
	} coef_t;

	// Result of one recursion step
	typedef struct packed {
		logic [SampleW-1:0] sample;
		logic               overflow;
	} result_t;

endpackage

// ===== src/iirdf_cfg_regs.sv =====
// Coefficient register file written through the plain configuration port.
module iirdf_cfg_regs
	import iirdf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_idx,
	input  logic [CfgDataW-1:0] cfg_wdata,
	output coef_t               coef
);

	coef_t coef_q;

	// Register writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_FWD_OLDEST: coef_q.fwd_coef_oldest <= cfg_wdata[FwdW-1:0];
				REG_FWD_MIDDLE: coef_q.fwd_coef_middle <= cfg_wdata[FwdW-1:0];
				REG_FWD_NEWEST: coef_q.fwd_coef_newest <= cfg_wdata[FwdW-1:0];
				REG_FB_OLDEST:  coef_q.fb_coef_oldest  <= cfg_wdata[FbW-1:0];
				REG_FB_RECENT:  coef_q.fb_coef_recent  <= cfg_wdata[FbW-1:0];
				REG_INV_GAIN:   coef_q.inv_gain        <= cfg_wdata[GainW-1:0];
				default: ;
			endcase
		end
	end

	assign coef = coef_q;

endmodule

// ===== src/iirdf_scale.sv =====
// Input stage: multiplies the sample by the reciprocal gain and registers the Q16.16 result.
module iirdf_scale
	import iirdf_pkg::*;
(
	input  logic                clk,
	input  logic                load,
	input  logic [SampleW-1:0]  sample_in,
	input  logic [GainW-1:0]    inv_gain,
	output logic [XW-1:0]       x_s1
);

	localparam int unsigned ProdW = SampleW + GainW + 1;

	logic signed [ProdW-1:0] prod;
	logic        [XW-1:0]    x_scaled_s1;

	// Signed sample times unsigned gain; taking bits above the fraction floors
	assign prod = $signed(sample_in) * $signed({1'b0, inv_gain});

	always_ff @(posedge clk) begin
		if (load) begin
			x_scaled_s1 <= prod[FracW+XW-1:FracW];
		end
	end

	assign x_s1 = x_scaled_s1;

endmodule

// ===== src/iirdf_recur.sv =====
// Recursion stage: input/output history, multiply-accumulate and saturation.
module iirdf_recur
	import iirdf_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic [XW-1:0]  x_new,
	input  coef_t          coef,
	output result_t        result
);

	localparam int unsigned FbProdW  = FbW + YW;        // 61
	localparam int unsigned FbSumW   = FbProdW + 1;     // 62
	localparam int unsigned FbPartW  = FbSumW - FracW;  // 46
	localparam int unsigned FwdProdW = FwdW + XW;       // 37
	localparam int unsigned AccW     = FbPartW + 2;     // 48
	localparam int unsigned IntW     = YW - FracW;      // 24

	logic signed [XW-1:0]       xh0_q, xh1_q;
	logic signed [YW-1:0]       yh0_q, yh1_q;
	logic signed [FbProdW-1:0]  p_fb0, p_fb1;
	logic signed [FbSumW-1:0]   fb_sum;
	logic signed [FbPartW-1:0]  fb_part;
	logic signed [FwdProdW-1:0] p_fw0, p_fw1, p_fw2;
	logic signed [AccW-1:0]     acc;
	logic        [YW-1:0]       y_sat;
	logic                       hist_ovf;
	logic        [IntW-1:0]     y_int;
	logic        [SampleW-1:0]  o_sat;
	logic                       out_ovf;

	// Feedback products, summed at 32 fraction bits then floored to 16
	assign p_fb0   = $signed(coef.fb_coef_oldest) * yh0_q;
	assign p_fb1   = $signed(coef.fb_coef_recent) * yh1_q;
	assign fb_sum  = {p_fb0[FbProdW-1], p_fb0} + {p_fb1[FbProdW-1], p_fb1};
	assign fb_part = fb_sum[FbSumW-1:FracW];

	// Feed-forward products are whole multiples of the Q.16 step
	assign p_fw0 = $signed(coef.fwd_coef_oldest) * xh0_q;
	assign p_fw1 = $signed(coef.fwd_coef_middle) * xh1_q;
	assign p_fw2 = $signed(coef.fwd_coef_newest) * $signed(x_new);

	assign acc = {{(AccW-FbPartW){fb_part[FbPartW-1]}}, fb_part}
		+ {{(AccW-FwdProdW){p_fw0[FwdProdW-1]}}, p_fw0}
		+ {{(AccW-FwdProdW){p_fw1[FwdProdW-1]}}, p_fw1}
		+ {{(AccW-FwdProdW){p_fw2[FwdProdW-1]}}, p_fw2};

	// Clamp to the 40-bit history range
	always_comb begin
		hist_ovf = !((&acc[AccW-1:YW-1]) || !(|acc[AccW-1:YW-1]));
		if (!hist_ovf) begin
			y_sat = acc[YW-1:0];
		end else if (acc[AccW-1]) begin
			y_sat = {1'b1, {(YW-1){1'b0}}};
		end else begin
			y_sat = {1'b0, {(YW-1){1'b1}}};
		end
	end

	// Drop the fraction and clamp to the sample range
	assign y_int = y_sat[YW-1:FracW];
	always_comb begin
		out_ovf = !((&y_int[IntW-1:SampleW-1]) || !(|y_int[IntW-1:SampleW-1]));
		if (!out_ovf) begin
			o_sat = y_int[SampleW-1:0];
		end else if (y_int[IntW-1]) begin
			o_sat = {1'b1, {(SampleW-1){1'b0}}};
		end else begin
			o_sat = {1'b0, {(SampleW-1){1'b1}}};
		end
	end

	assign result.sample   = o_sat;
	assign result.overflow = hist_ovf | out_ovf;

	// History shifts once per item leaving the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xh0_q <= '0;
			xh1_q <= '0;
			yh0_q <= '0;
			yh1_q <= '0;
		end else if (step) begin
			xh0_q <= xh1_q;
			xh1_q <= x_new;
			yh0_q <= yh1_q;
			yh1_q <= y_sat;
		end
	end

endmodule

// ===== src/iir_direct_form_filter_core.sv =====
// Top level of the second-order direct form 1 IIR filter core.
//
// Input items (sample_in) arrive on in_valid/in_ready, results (sample_out,
// overflow) leave on out_valid/out_ready; an item moves on an edge where valid and
// ready are both high. Coefficients load via cfg_we, cfg_idx and cfg_wdata, one
// register per edge; the user must do so only with no item in flight (unchecked).
//
// Two stages: the input register holds the sample scaled by inv_gain, the
// output register holds the filtered result. A result passes through the input
// and output registers before it is offered. The feedback loop closes inside
// the second stage, so one item is taken every cycle while out_ready stays high.
//
// Reset clears coefficients, history and both stage valid flags; the block
// is ready for an item as soon as reset is released. When the receiver holds
// out_ready low the output register keeps its result, the scaled item waits
// in the input register, and in_ready drops once both are full. Up to two
// items can be held at once. History advances only as an item enters the
// output register, so stalls never disturb the recursion.
module iir_direct_form_filter_core
	import iirdf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_idx,
	input  logic [CfgDataW-1:0] cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [SampleW-1:0]  sample_in,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SampleW-1:0]  sample_out,
	output logic                overflow
);

	coef_t              coef;
	logic [XW-1:0]      x_s1;
	logic               valid_s1;
	logic               advance;
	logic               load_s1;
	logic               step_s2;
	result_t            result;
	logic               valid_s2;
	result_t            result_s2;

	// Stage control
	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign load_s1  = in_valid && in_ready;
	assign step_s2  = valid_s1 && advance;

	iirdf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.coef      (coef)
	);

	iirdf_scale u_scale (
		.clk       (clk),
		.load      (load_s1),
		.sample_in (sample_in),
		.inv_gain  (coef.inv_gain),
		.x_s1      (x_s1)
	);

	iirdf_recur u_recur (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step_s2),
		.x_new  (x_s1),
		.coef   (coef),
		.result (result)
	);

	// Valid flags of both stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (step_s2) begin
			result_s2 <= result;
		end
	end

	assign out_valid  = valid_s2;
	assign sample_out = result_s2.sample;
	assign overflow   = result_s2.overflow;

	// A waiting scaled item is never dropped during a stall
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("scaled item lost while output stalled");

	// in_ready only falls with both stages full and the receiver stalled
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2 && !out_ready)
		else $error("input stalled without cause");

	// Any saturation pins the output sample to a rail
	a_ovf_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |->
			sample_out == {1'b0, {(SampleW-1){1'b1}}} ||
			sample_out == {1'b1, {(SampleW-1){1'b0}}})
		else $error("overflow flagged on an unclamped sample");

	// An accepted item shows up as a result once the pipeline advances after the load
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		load_s1 ##1 advance |=> out_valid)
		else $error("result missing after pipeline advance");

endmodule
